// ===== rtl/tpf_pkg.sv =====
// Shared types, codes and constants of the touch position filter.
package tpf_pkg;

  // Field and register widths
  localparam int WS_W      = 7;
  localparam int LIMIT_W   = 24;
  localparam int RD_W      = 8;
  localparam int PX_W      = 8;
  localparam int PY_W      = 9;
  localparam int EV_W      = 2;
  localparam int CNT_W     = 7;
  localparam int SQ_W      = 16;
  localparam int PROD_W    = 15;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'd1;
  localparam logic [WS_W-1:0]      WS_RESET    = 7'd8;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 24'd4000;
  localparam int                   MAX_SAMPLES_DEF = 64;

  // Arithmetic constants
  localparam logic [LIMIT_W-1:0] DEV_MAX     = 24'hFFFFFF;
  localparam logic [RD_W-1:0]    BAD_READING = 8'hFF;
  localparam logic [8:0]         X_OFFSET    = 9'd23;
  localparam logic [8:0]         X_TOP       = 9'd262;  // 239 + offset
  localparam logic [PX_W-1:0]    X_MAX       = 8'd239;
  localparam logic [RD_W-1:0]    Y_BASE      = 8'd240;
  localparam logic [PY_W-1:0]    Y_MAX       = 9'd319;
  // floor(10*a/9) == (a * RECIP_10_9) >> RECIP_SH, exact for a <= 255
  localparam logic [15:0]        RECIP_10_9  = 16'd36410;
  localparam int                 RECIP_SH    = 15;

  // Divider geometry
  localparam int DIV_W     = 24;
  localparam int DIVR_W    = 7;
  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Event codes
  localparam logic [EV_W-1:0] EV_NONE = 2'd0;
  localparam logic [EV_W-1:0] EV_DOWN = 2'd1;
  localparam logic [EV_W-1:0] EV_UP   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS_CNT,
    S_POS_ACC,
    S_DIV_X,
    S_DIV_Y,
    S_POS_CHK,
    S_NORM1,
    S_NORM2,
    S_CONV,
    S_POS_CLOSE,
    S_PRES_CNT,
    S_PRES_CHK,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DS_NUM_X,
    DS_NUM_Y,
    DS_SUM,
    DS_QUOT
  } div_src_t;

  typedef struct packed {
    logic     load;
    logic     pos_count;
    logic     pos_acc;
    logic     div_start;
    div_src_t div_src;
    logic     avg_x_wr;
    logic     avg_y_wr;
    logic     conv;
    logic     pos_close;
    logic     pres_step;
    logic     pres_close;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic good;
    logic all_good;
    logic pos_due;
    logic pres_due;
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/touch_position_filter.sv =====
// Touch position filter: windowed averaging, deviation check and pen presence.
// Presence items are counted and checked; a position item with a bad reading is counted
// and checked; a good one also runs two divides for the running averages, and two more
// normalise the deviation sum when it closes a window whose readings were all good.
// One item at a time; a finished result waits in the output register, a held one stalls it.
// Synchronous active-low reset: pen up, all accumulators and positions zero.
module touch_position_filter #(
  parameter int MAX_SAMPLES = tpf_pkg::MAX_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpf_pkg::LIMIT_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic                          in_pen_pin,
  input  logic [tpf_pkg::RD_W-1:0]      in_x_reading,
  input  logic [tpf_pkg::RD_W-1:0]      in_y_reading,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tpf_pkg::EV_W-1:0]      out_event_res,
  output logic                          out_position_updated,
  output logic [tpf_pkg::PX_W-1:0]      out_pos_x,
  output logic [tpf_pkg::PY_W-1:0]      out_pos_y,
  output logic                          out_pen_is_down
);
  import tpf_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  tpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tpf_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_op                (in_op),
    .in_pen_pin           (in_pen_pin),
    .in_x_reading         (in_x_reading),
    .in_y_reading         (in_y_reading),
    .out_event_res        (out_event_res),
    .out_position_updated (out_position_updated),
    .out_pos_x            (out_pos_x),
    .out_pos_y            (out_pos_y),
    .out_pen_is_down      (out_pen_is_down)
  );

endmodule

// ===== rtl/tpf_div.sv =====
// Iterative unsigned divider, two quotient bits per cycle.
module tpf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tpf_pkg::DIV_W-1:0]  dividend,
  input  logic [tpf_pkg::DIVR_W-1:0] divisor,
  output logic [tpf_pkg::DIV_W-1:0]  quotient,
  output logic                       done
);
  import tpf_pkg::*;

  logic [DIVR_W-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]     quot_r, quot_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  // Each step shifts two dividend bits into the remainder, one at a time, subtracting where it fits.
  always_comb begin
    logic [DIVR_W:0] part;
    logic [DIV_W-1:0] q;
    part = '0;
    q = quot_r;
    rem_nxt = rem_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      part = {rem_nxt, q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (part >= {1'b0, divisor}) begin
        part = part - {1'b0, divisor};
        q[0] = 1'b1;
      end
      rem_nxt = part[DIVR_W-1:0];
    end
    quot_nxt = q;
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quot_r <= dividend;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign quotient = quot_r;
  assign done     = done_r;

endmodule

// ===== rtl/tpf_datapath.sv =====
// Datapath: configuration, accumulators, divider and position conversion.
module tpf_datapath #(
  parameter int MAX_SAMPLES = tpf_pkg::MAX_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tpf_pkg::cmd_t                 cmd,
  output tpf_pkg::sts_t                 sts,
  input  logic                          cfg_we,
  input  logic [tpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpf_pkg::LIMIT_W-1:0]   cfg_data,
  input  logic                          in_op,
  input  logic                          in_pen_pin,
  input  logic [tpf_pkg::RD_W-1:0]      in_x_reading,
  input  logic [tpf_pkg::RD_W-1:0]      in_y_reading,
  output logic [tpf_pkg::EV_W-1:0]      out_event_res,
  output logic                          out_position_updated,
  output logic [tpf_pkg::PX_W-1:0]      out_pos_x,
  output logic [tpf_pkg::PY_W-1:0]      out_pos_y,
  output logic                          out_pen_is_down
);
  import tpf_pkg::*;

  localparam logic [8:0] MAX_N = 9'(MAX_SAMPLES);

  logic [WS_W-1:0]    ws_r;
  logic [LIMIT_W-1:0] limit_r;

  logic               op_r, pin_r;
  logic [RD_W-1:0]    x_r, y_r;

  logic [RD_W-1:0]    avg_x_r, avg_y_r;
  logic [LIMIT_W-1:0] dev_sum_r;
  logic [CNT_W-1:0]   gc_r, psc_r, hc_r, prc_r;
  logic [PX_W-1:0]    stored_x_r;
  logic [PY_W-1:0]    stored_y_r;
  logic               pen_down_r;
  logic [EV_W-1:0]    ev_r;
  logic               upd_r;

  logic [SQ_W-1:0]    dx2_r, dy2_r;
  logic [PROD_W-1:0]  prod_x_r, prod_y_r;

  logic [CNT_W-1:0]   win_n;
  logic               good;
  logic [RD_W-1:0]    dx, dy;
  logic [LIMIT_W:0]   dev_add;
  logic [LIMIT_W-1:0] dev_sum_nxt;

  logic               div_start;
  logic [DIV_W-1:0]   div_dividend, div_q;
  logic               div_done;

  logic [23:0]        xprod;
  logic [8:0]         xq;
  logic [PX_W-1:0]    px;
  logic [RD_W-1:0]    yt;
  logic [9:0]         y3;
  logic [PY_W-1:0]    yh, py;

  // Window length: zero acts as one, clip at MAX_SAMPLES.
  always_comb begin
    if (ws_r == '0) begin
      win_n = CNT_W'(1);
    end else if ({2'b00, ws_r} > MAX_N) begin
      win_n = MAX_N[CNT_W-1:0];
    end else begin
      win_n = ws_r;
    end
  end

  assign good = !pin_r && (x_r != BAD_READING) && (y_r != BAD_READING);
  assign dx   = (avg_x_r > x_r) ? (avg_x_r - x_r) : (x_r - avg_x_r);
  assign dy   = (avg_y_r > y_r) ? (avg_y_r - y_r) : (y_r - avg_y_r);

  // Saturating deviation accumulate
  assign dev_add = {1'b0, dev_sum_r} + (LIMIT_W+1)'(dx2_r) + (LIMIT_W+1)'(dy2_r);
  assign dev_sum_nxt = dev_add[LIMIT_W] ? DEV_MAX : dev_add[LIMIT_W-1:0];

  always_comb begin
    case (cmd.div_src)
      DS_NUM_X: div_dividend = DIV_W'(prod_x_r) + DIV_W'(x_r);
      DS_NUM_Y: div_dividend = DIV_W'(prod_y_r) + DIV_W'(y_r);
      DS_SUM:   div_dividend = dev_sum_r;
      DS_QUOT:  div_dividend = div_q;
      default:  div_dividend = '0;
    endcase
  end

  assign div_start = cmd.div_start;

  tpf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gc_r),
    .quotient (div_q),
    .done     (div_done)
  );

  // X: floor(10*avg/9) - 23, clamped to the panel width
  assign xprod = 24'(avg_x_r) * 24'(RECIP_10_9);
  assign xq    = xprod[RECIP_SH +: 9];
  always_comb begin
    if (xq < X_OFFSET) begin
      px = '0;
    end else if (xq > X_TOP) begin
      px = X_MAX;
    end else begin
      px = PX_W'(xq - X_OFFSET);
    end
  end

  // Y: (240 - avg) * 3 / 2, clamped to the panel height
  assign yt = Y_BASE - avg_y_r;
  assign y3 = {2'b00, yt} + {1'b0, yt, 1'b0};
  assign yh = y3[9:1];
  always_comb begin
    if (avg_y_r > Y_BASE) begin
      py = '0;
    end else if (yh > Y_MAX) begin
      py = Y_MAX;
    end else begin
      py = yh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r       <= WS_RESET;
      limit_r    <= LIMIT_RESET;
      avg_x_r    <= '0;
      avg_y_r    <= '0;
      dev_sum_r  <= '0;
      gc_r       <= '0;
      psc_r      <= '0;
      hc_r       <= '0;
      prc_r      <= '0;
      stored_x_r <= '0;
      stored_y_r <= '0;
      pen_down_r <= 1'b0;
      ev_r       <= EV_NONE;
      upd_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW: ws_r    <= cfg_data[WS_W-1:0];
          CFG_LIMIT:  limit_r <= cfg_data;
          default:    ;
        endcase
      end
      if (cmd.load) begin
        upd_r <= 1'b0;
        ev_r  <= EV_NONE;
      end
      if (cmd.pos_count) begin
        psc_r <= psc_r + 1'b1;
        if (good) begin
          gc_r <= gc_r + 1'b1;
        end
      end
      if (cmd.pos_acc) begin
        dev_sum_r <= dev_sum_nxt;
      end
      if (cmd.avg_x_wr) begin
        avg_x_r <= div_q[RD_W-1:0];
      end
      if (cmd.avg_y_wr) begin
        avg_y_r <= div_q[RD_W-1:0];
      end
      if (cmd.conv && (div_q < limit_r)) begin
        stored_x_r <= px;
        stored_y_r <= py;
        upd_r      <= 1'b1;
      end
      if (cmd.pos_close) begin
        avg_x_r   <= '0;
        avg_y_r   <= '0;
        dev_sum_r <= '0;
        gc_r      <= '0;
        psc_r     <= '0;
      end
      if (cmd.pres_step) begin
        hc_r  <= hc_r + CNT_W'(pin_r);
        prc_r <= prc_r + 1'b1;
      end
      if (cmd.pres_close) begin
        if (hc_r == prc_r) begin
          if (!pen_down_r) begin
            pen_down_r <= 1'b1;
            ev_r       <= EV_DOWN;
          end
        end else if (pen_down_r) begin
          pen_down_r <= 1'b0;
          ev_r       <= EV_UP;
        end
        hc_r  <= '0;
        prc_r <= '0;
      end
    end
  end

  // Payload registers: item fields, products, result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      pin_r <= in_pen_pin;
      x_r   <= in_x_reading;
      y_r   <= in_y_reading;
    end
    if (cmd.pos_count) begin
      dx2_r    <= SQ_W'(dx) * SQ_W'(dx);
      dy2_r    <= SQ_W'(dy) * SQ_W'(dy);
      prod_x_r <= PROD_W'(avg_x_r) * PROD_W'(gc_r);
      prod_y_r <= PROD_W'(avg_y_r) * PROD_W'(gc_r);
    end
    if (cmd.emit) begin
      out_event_res        <= ev_r;
      out_position_updated <= upd_r;
      out_pos_x            <= stored_x_r;
      out_pos_y            <= stored_y_r;
      out_pen_is_down      <= pen_down_r;
    end
  end

  always_comb begin
    sts.good     = good && !op_r;
    sts.all_good = (gc_r == psc_r);
    sts.pos_due  = (psc_r >= win_n);
    sts.pres_due = (prc_r >= win_n);
    sts.div_done = div_done;
  end

endmodule

// ===== rtl/tpf_ctrl.sv =====
// Controller state machine: sequences item handling and result hand-off.
module tpf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  tpf_pkg::sts_t sts,
  output tpf_pkg::cmd_t cmd
);
  import tpf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   can_emit;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign can_emit = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = in_op ? S_PRES_CNT : S_POS_CNT;
        end
      end
      S_POS_CNT:   state_nxt = sts.good ? S_POS_ACC : S_POS_CHK;
      S_POS_ACC:   state_nxt = S_DIV_X;
      S_DIV_X:     if (sts.div_done) state_nxt = S_DIV_Y;
      S_DIV_Y:     if (sts.div_done) state_nxt = S_POS_CHK;
      S_POS_CHK: begin
        if (!sts.pos_due) begin
          state_nxt = S_IDLE;
        end else if (sts.all_good) begin
          state_nxt = S_NORM1;
        end else begin
          state_nxt = S_POS_CLOSE;
        end
      end
      S_NORM1:     if (sts.div_done) state_nxt = S_NORM2;
      S_NORM2:     if (sts.div_done) state_nxt = S_CONV;
      S_CONV:      state_nxt = S_POS_CLOSE;
      S_POS_CLOSE: state_nxt = S_EMIT;
      S_PRES_CNT:  state_nxt = S_PRES_CHK;
      S_PRES_CHK:  state_nxt = sts.pres_due ? S_EMIT : S_IDLE;
      S_EMIT:      if (can_emit) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_src = DS_NUM_X;
    cmd.load = accept;
    case (state_r)
      S_POS_CNT: cmd.pos_count = 1'b1;
      S_POS_ACC: begin
        cmd.pos_acc   = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_src   = DS_NUM_X;
      end
      S_DIV_X: begin
        if (sts.div_done) begin
          cmd.avg_x_wr  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_src   = DS_NUM_Y;
        end
      end
      S_DIV_Y:   cmd.avg_y_wr = sts.div_done;
      S_POS_CHK: begin
        if (sts.pos_due && sts.all_good) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DS_SUM;
        end
      end
      S_NORM1: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DS_QUOT;
        end
      end
      S_CONV:      cmd.conv       = 1'b1;
      S_POS_CLOSE: cmd.pos_close  = 1'b1;
      S_PRES_CNT:  cmd.pres_step  = 1'b1;
      S_PRES_CHK:  cmd.pres_close = sts.pres_due;
      S_EMIT:      cmd.emit       = can_emit;
      default:     ;
    endcase
  end

  // Hold the result until taken; a new one may load as the old one leaves.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== tb/touch_position_filter_test.sv =====
// Self-checking testbench for the touch position filter: directed table, then random windows.
`timescale 1ns / 100ps

module touch_position_filter_test;
  import tpf_pkg::*;

  typedef struct packed {
    logic [EV_W-1:0] ev;
    logic            upd;
    logic [PX_W-1:0] px;
    logic [PY_W-1:0] py;
    logic            dn;
  } touch_result_t;

  typedef struct packed {
    logic            op;
    logic            pin;
    logic [RD_W-1:0] x;
    logic [RD_W-1:0] y;
    logic            typed;
    touch_result_t   res;
  } touch_row_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  localparam int WINDOW_CAP      = MAX_SAMPLES_DEF;
  localparam int STAGES          = 10;
  localparam int ITEMS_PER_STAGE = 155;
  localparam int SETTLE_CYCLES   = 100;
  localparam int DRAIN_LIMIT     = 20000;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [LIMIT_W-1:0]   cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic                 in_op        = 1'b0;
  logic                 in_pen_pin   = 1'b0;
  logic [RD_W-1:0]      in_x_reading = '0;
  logic [RD_W-1:0]      in_y_reading = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [EV_W-1:0]      out_event_res;
  logic                 out_position_updated;
  logic [PX_W-1:0]      out_pos_x;
  logic [PY_W-1:0]      out_pos_y;
  logic                 out_pen_is_down;

  touch_position_filter u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Filter state as predicted, starting from the reset state
  logic [WS_W-1:0]    ws_reg    = WS_RESET;
  logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;
  logic [RD_W-1:0]    avg_x_m   = '0;
  logic [RD_W-1:0]    avg_y_m   = '0;
  logic [LIMIT_W-1:0] dev_acc   = '0;
  logic [CNT_W-1:0]   good_cnt  = '0;
  logic [CNT_W-1:0]   pos_cnt   = '0;
  logic [CNT_W-1:0]   high_cnt  = '0;
  logic [CNT_W-1:0]   pres_cnt  = '0;
  logic [PX_W-1:0]    pix_x     = '0;
  logic [PY_W-1:0]    pix_y     = '0;
  logic               pen_dn    = 1'b0;

  touch_result_t expected_results[$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned items_sent      = 0;
  int unsigned results_seen    = 0;
  int unsigned updates_seen    = 0;
  int unsigned events_seen     = 0;
  int unsigned settings_used   = 0;
  int unsigned mismatches      = 0;

  // Window 1 and widest limit: every row closes a window
  touch_row_t directed_rows [20] = '{
    '{1'b0, 1'b0, 8'd0,   8'd0,   1'b1, '{EV_NONE, 1'b1, 8'd0,   9'd319, 1'b0}},
    '{1'b0, 1'b0, 8'd254, 8'd254, 1'b1, '{EV_NONE, 1'b1, 8'd239, 9'd0,   1'b0}},
    '{1'b0, 1'b1, 8'd100, 8'd100, 1'b1, '{EV_NONE, 1'b0, 8'd239, 9'd0,   1'b0}},
    '{1'b0, 1'b0, 8'd255, 8'd10,  1'b1, '{EV_NONE, 1'b0, 8'd239, 9'd0,   1'b0}},
    '{1'b0, 1'b0, 8'd10,  8'd255, 1'b1, '{EV_NONE, 1'b0, 8'd239, 9'd0,   1'b0}},
    '{1'b0, 1'b0, 8'd255, 8'd255, 1'b1, '{EV_NONE, 1'b0, 8'd239, 9'd0,   1'b0}},
    '{1'b0, 1'b0, 8'd100, 8'd100, 1'b1, '{EV_NONE, 1'b1, 8'd88,  9'd210, 1'b0}},
    '{1'b1, 1'b1, 8'd255, 8'd255, 1'b1, '{EV_DOWN, 1'b0, 8'd88,  9'd210, 1'b1}},
    '{1'b1, 1'b1, 8'd0,   8'd0,   1'b1, '{EV_NONE, 1'b0, 8'd88,  9'd210, 1'b1}},
    '{1'b0, 1'b1, 8'd50,  8'd50,  1'b1, '{EV_NONE, 1'b0, 8'd88,  9'd210, 1'b1}},
    '{1'b0, 1'b0, 8'd20,  8'd240, 1'b1, '{EV_NONE, 1'b1, 8'd0,   9'd0,   1'b1}},
    '{1'b1, 1'b0, 8'd0,   8'd0,   1'b1, '{EV_UP,   1'b0, 8'd0,   9'd0,   1'b0}},
    '{1'b1, 1'b0, 8'd255, 8'd0,   1'b1, '{EV_NONE, 1'b0, 8'd0,   9'd0,   1'b0}},
    '{1'b0, 1'b0, 8'd237, 8'd26,  1'b1, '{EV_NONE, 1'b1, 8'd239, 9'd319, 1'b0}},
    '{1'b0, 1'b0, 8'd236, 8'd27,  1'b1, '{EV_NONE, 1'b1, 8'd239, 9'd319, 1'b0}},
    '{1'b0, 1'b0, 8'd23,  8'd241, 1'b1, '{EV_NONE, 1'b1, 8'd2,   9'd0,   1'b0}},
    '{1'b0, 1'b0, 8'd137, 8'd77,  1'b0, '0},
    '{1'b1, 1'b1, 8'd170, 8'd85,  1'b0, '0},
    '{1'b0, 1'b0, 8'd85,  8'd170, 1'b0, '0},
    '{1'b1, 1'b0, 8'h55,  8'hAA,  1'b0, '0}
  };

  // Advance the predicted filter by one item; produced is set when a window closes
  task automatic filter_touch_item(input logic op, input logic pin,
                                   input logic [RD_W-1:0] xr, input logic [RD_W-1:0] yr,
                                   output bit produced, output touch_result_t res);
    int unsigned n;
    int unsigned cnt;
    int unsigned norm;
    int          dx;
    int          dy;
    int          px;
    int          py;
    logic [31:0] sum;
    logic        upd;
    logic [EV_W-1:0] ev;
    n = 32'(ws_reg);
    if (n == 0) n = 1;
    if (n > WINDOW_CAP) n = WINDOW_CAP;
    produced = 1'b0;
    res = '0;
    upd = 1'b0;
    ev = EV_NONE;
    if (!op) begin
      if (!pin && xr != BAD_READING && yr != BAD_READING) begin
        dx = int'(avg_x_m) - int'(xr);
        dy = int'(avg_y_m) - int'(yr);
        good_cnt = good_cnt + 1'b1;
        sum = dev_acc + 32'(dx * dx + dy * dy);
        dev_acc = (sum > DEV_MAX) ? DEV_MAX : sum[LIMIT_W-1:0];
        cnt = 32'(good_cnt);
        avg_x_m = RD_W'((avg_x_m * (cnt - 1) + xr) / cnt);
        avg_y_m = RD_W'((avg_y_m * (cnt - 1) + yr) / cnt);
      end
      pos_cnt = pos_cnt + 1'b1;
      if (pos_cnt >= n) begin
        if (good_cnt == pos_cnt) begin
          cnt = 32'(good_cnt);
          norm = dev_acc / cnt / cnt;
          if (norm < limit_reg) begin
            px = int'(avg_x_m) * 10 / 9 - 23;
            py = (240 - int'(avg_y_m)) * 3 / 2;
            if (px < 0) px = 0;
            if (px > int'(X_MAX)) px = int'(X_MAX);
            if (py < 0) py = 0;
            if (py > int'(Y_MAX)) py = int'(Y_MAX);
            pix_x = PX_W'(px);
            pix_y = PY_W'(py);
            upd = 1'b1;
          end
        end
        avg_x_m = '0;
        avg_y_m = '0;
        dev_acc = '0;
        good_cnt = '0;
        pos_cnt = '0;
        produced = 1'b1;
      end
    end else begin
      if (pin) high_cnt = high_cnt + 1'b1;
      pres_cnt = pres_cnt + 1'b1;
      if (pres_cnt >= n) begin
        if (high_cnt == pres_cnt) begin
          if (!pen_dn) begin
            pen_dn = 1'b1;
            ev = EV_DOWN;
          end
        end else if (pen_dn) begin
          pen_dn = 1'b0;
          ev = EV_UP;
        end
        high_cnt = '0;
        pres_cnt = '0;
        produced = 1'b1;
      end
    end
    res = '{ev, upd, pix_x, pix_y, pen_dn};
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Offer one item after a random idle gap; predict it once accepted
  task automatic drive_item(input logic op, input logic pin,
                            input logic [RD_W-1:0] xr, input logic [RD_W-1:0] yr,
                            input bit typed, input touch_result_t typed_res);
    bit            produced;
    touch_result_t res;
    @(negedge clk);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_pen_pin   <= pin;
    in_x_reading <= xr;
    in_y_reading <= yr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    filter_touch_item(op, pin, xr, yr, produced, res);
    if (produced) expected_results.push_back(typed ? typed_res : res);
  endtask

  // Hold off the sender until every expected item has come, then let the block settle
  task automatic wait_drained();
    int waited;
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_WINDOW) ws_reg = data[WS_W-1:0];
    else limit_reg = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [RD_W-1:0] near_target(input int centre);
    int v;
    v = centre + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 254) v = 254;
    return RD_W'(v);
  endfunction

  function automatic int pick_target();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 254;
      default: return int'($urandom_range(0, 254));
    endcase
  endfunction

  always @(negedge clk)
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);

  always @(posedge clk) begin : result_check
    touch_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("item %0d with none expected: ev=%0d upd=%0d pos=(%0d,%0d)",
                                  results_seen, out_event_res, out_position_updated,
                                  out_pos_x, out_pos_y));
      end else begin
        want = expected_results.pop_front();
        updates_seen += want.upd;
        if (want.ev != EV_NONE) events_seen++;
        if (out_event_res !== want.ev)
          report_mismatch($sformatf("item %0d event_res %0d, want %0d",
                                    results_seen, out_event_res, want.ev));
        if (out_position_updated !== want.upd)
          report_mismatch($sformatf("item %0d position_updated %0d, want %0d",
                                    results_seen, out_position_updated, want.upd));
        if (out_pos_x !== want.px)
          report_mismatch($sformatf("item %0d pos_x %0d, want %0d",
                                    results_seen, out_pos_x, want.px));
        if (out_pos_y !== want.py)
          report_mismatch($sformatf("item %0d pos_y %0d, want %0d",
                                    results_seen, out_pos_y, want.py));
        if (out_pen_is_down !== want.dn)
          report_mismatch($sformatf("item %0d pen_is_down %0d, want %0d",
                                    results_seen, out_pen_is_down, want.dn));
      end
    end
  end

  initial begin : stimulus
    int unsigned stage_ws [STAGES];
    int unsigned stage_lim [STAGES];
    idle_mode_t  stage_mode [STAGES];
    logic            op_r;
    logic            pin_r;
    logic [RD_W-1:0] x_r;
    logic [RD_W-1:0] y_r;
    bit          touching;
    int          tgt_x;
    int          tgt_y;
    int unsigned roll;
    stage_ws   = '{8, 1, 64, 127, 3, 2, 0, 5, 4, 16};
    stage_lim  = '{4000, 0, 24'hFFFFFF, 4000, 1, 200, 0, 100000, 50, 3000};
    stage_mode = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE,
                   IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE, IDLE_BOTH};
    stage_ws[6]  = $urandom_range(1, 16);
    stage_lim[6] = $urandom_range(0, 2000);
    touching = 1'b0;
    tgt_x = pick_target();
    tgt_y = pick_target();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Window length 0 acts as 1, so every directed item closes a window
    write_register(CFG_WINDOW, '0);
    write_register(CFG_LIMIT, DEV_MAX);
    settings_used++;
    foreach (directed_rows[i])
      drive_item(directed_rows[i].op, directed_rows[i].pin, directed_rows[i].x,
                 directed_rows[i].y, directed_rows[i].typed, directed_rows[i].res);
    wait_drained();

    // Partial windows carry over each rewrite, so shorter windows close early
    for (int s = 0; s < STAGES; s++) begin
      write_register(CFG_WINDOW, {(LIMIT_W-WS_W)'($urandom), WS_W'(stage_ws[s])});
      write_register(CFG_LIMIT, LIMIT_W'(stage_lim[s]));
      settings_used++;
      case (stage_mode[s])
        IDLE_NONE: begin
          sender_idle_pct = 0;
          recv_stall_pct = 0;
        end
        IDLE_SENDER: begin
          sender_idle_pct = 77;
          recv_stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          sender_idle_pct = 0;
          recv_stall_pct = 77;
        end
        default: begin
          sender_idle_pct = 37;
          recv_stall_pct = 37;
        end
      endcase
      for (int k = 0; k < ITEMS_PER_STAGE; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
          // presence: mostly the current touch level, now and then a glitch
          op_r = 1'b1;
          pin_r = ($urandom_range(0, 9) == 0) ? 1'($urandom) : touching;
          x_r = RD_W'($urandom);
          y_r = RD_W'($urandom);
        end else if (roll < 85) begin
          // steady touch near the current target
          op_r = 1'b0;
          pin_r = 1'b0;
          x_r = near_target(tgt_x);
          y_r = near_target(tgt_y);
        end else begin
          op_r = 1'b0;
          pin_r = 1'($urandom);
          x_r = ($urandom_range(0, 3) == 0) ? BAD_READING : RD_W'($urandom);
          y_r = ($urandom_range(0, 3) == 0) ? BAD_READING : RD_W'($urandom);
        end
        if ($urandom_range(0, 39) == 0) touching = !touching;
        if ($urandom_range(0, 29) == 0) begin
          tgt_x = pick_target();
          tgt_y = pick_target();
        end
        if ($urandom_range(0, 149) == 0) wait_drained();
        drive_item(op_r, pin_r, x_r, y_r, 1'b0, '0);
      end
      wait_drained();
    end

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected items never came", expected_results.size()));
    $display("Sent %0d items (%0d from the table) across %0d register settings",
             items_sent, $size(directed_rows), settings_used);
    $display("and four idle mixes; checked %0d window results: %0d position updates, %0d pen events.",
             results_seen, updates_seen, events_seen);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
